/* sv/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define BMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define BMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bmc_pkg.sv */
// types and constants shared by the block move counter modules
`timescale 1ns / 1ps

package bmc_pkg;

    localparam int RANK_W = 9;
    localparam int LEN_W  = 32;
    localparam int TGT_W  = RANK_W + 1;
    localparam int BIN_W  = 6;
    localparam int CNT_W  = 8;

    typedef struct packed {
        logic [RANK_W-1:0] segment_rank;
        logic [LEN_W-1:0]  segment_length;
        logic              last_segment;
    } request_t;

    typedef struct packed {
        logic [BIN_W-1:0] bin_index;
        logic [CNT_W-1:0] bin_moves;
        logic [CNT_W-1:0] moves_total;
        logic             last_bin;
    } result_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [LEN_W-1:0]  len;
        logic              dup;
        logic              ins;
        logic              del;
    } cell_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_ROT,
        OP_CLR,
        OP_MERGE,
        OP_DEL,
        OP_INS
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [RANK_W-1:0] rank;
        logic [LEN_W-1:0]  len;
        logic [RANK_W-1:0] base;
        logic [TGT_W-1:0]  ins_tgt;
        logic [TGT_W-1:0]  del_tgt;
        logic              ins_en;
        logic              del_en;
        logic              dup_en;
    } bcast_t;

endpackage

/* sv/bmc_cell.sv */
// one segment cell of the rotating segment chain
`timescale 1ns / 1ps

module bmc_cell
    import bmc_pkg::*;
#(
    parameter int MAX_SEGMENTS = 256,
    parameter int IDX          = 0
)
(
    input  logic                            clk,
    input  bcast_t                          bc,
    input  logic [$clog2(MAX_SEGMENTS)-1:0] pos,
    input  logic [$clog2(MAX_SEGMENTS)-1:0] last,
    input  cell_t                           right_eff,
    input  cell_t                           left_q,
    input  cell_t                           head_eff,
    output cell_t                           q,
    output cell_t                           eff
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    cell_t cell_reg;
    cell_t cell_next;
    logic  in_range;

    assign q        = cell_reg;
    assign in_range = MY_IDX <= last;

    always_comb
    begin
        eff = cell_reg;
        if (bc.dup_en && in_range && MY_IDX != '0 && cell_reg.rank == bc.rank)
        begin
            eff.dup = 1'b1;
        end
        if (bc.ins_en && in_range && TGT_W'(cell_reg.rank) == bc.ins_tgt)
        begin
            eff.ins = 1'b1;
        end
        if (bc.del_en && in_range && TGT_W'(cell_reg.rank) == bc.del_tgt)
        begin
            eff.del = 1'b1;
        end
        if (bc.op == OP_MERGE && cell_reg.rank > bc.base)
        begin
            eff.rank = cell_reg.rank - RANK_W'(1);
        end
    end

    always_comb
    begin
        cell_next = cell_reg;
        unique case (bc.op)
            OP_HOLD:
            begin
                cell_next = cell_reg;
            end
            OP_LOAD:
            begin
                if (MY_IDX == pos)
                begin
                    cell_next = '{rank: bc.rank, len: bc.len, dup: 1'b0, ins: 1'b0, del: 1'b0};
                end
            end
            OP_ROT:
            begin
                if (in_range)
                begin
                    cell_next = (MY_IDX == last) ? head_eff : right_eff;
                end
            end
            OP_CLR:
            begin
                cell_next.dup = 1'b0;
                cell_next.ins = 1'b0;
                cell_next.del = 1'b0;
            end
            OP_MERGE:
            begin
                if (MY_IDX == pos)
                begin
                    cell_next     = eff;
                    cell_next.len = bc.len;
                end
                else if (MY_IDX > pos)
                begin
                    cell_next = right_eff;
                end
                else
                begin
                    cell_next = eff;
                end
            end
            OP_DEL:
            begin
                if (MY_IDX >= pos)
                begin
                    cell_next = right_eff;
                end
            end
            OP_INS:
            begin
                if (MY_IDX == pos)
                begin
                    cell_next = '{rank: bc.rank, len: bc.len, dup: 1'b0, ins: 1'b0, del: 1'b0};
                end
                else if (MY_IDX > pos)
                begin
                    cell_next = left_q;
                end
            end
            default:
            begin
                cell_next = cell_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

endmodule

/* sv/bmc_hist.sv */
// move length histogram, one counter per bin, shifted out toward bin one
`timescale 1ns / 1ps

module bmc_hist
    import bmc_pkg::*;
#(
    parameter int MAX_MOVE_LEN = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              inc,
    input  logic [$clog2(MAX_MOVE_LEN+1)-1:0] bin,
    input  logic                              shift,
    output logic [CNT_W-1:0]                  head
);

    localparam int HBW = $clog2(MAX_MOVE_LEN + 1);

    logic [CNT_W-1:0] hist_reg [MAX_MOVE_LEN];

    assign head = hist_reg[0];

    for (genvar j = 0; j < MAX_MOVE_LEN; j++)
    begin : g_bin
        localparam logic [HBW-1:0] MY_BIN = HBW'(j + 1);
        logic [CNT_W-1:0] shift_in;

        if (j == MAX_MOVE_LEN - 1)
        begin : g_top
            assign shift_in = '0;
        end
        else
        begin : g_mid
            assign shift_in = hist_reg[j + 1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hist_reg[j] <= '0;
            end
            else if (shift)
            begin
                hist_reg[j] <= shift_in;
            end
            else if (inc && bin == MY_BIN && hist_reg[j] != {CNT_W{1'b1}})
            begin
                hist_reg[j] <= hist_reg[j] + CNT_W'(1);
            end
        end
    end

endmodule

/* sv/block_move_counter.sv */
// block move counter top level: segment chain, sequencer and histogram
// Usage:
//   Segments arrive on request (rank, length, last flag). One request is
//   taken at each rising edge with start high and busy low, one per cycle
//   while loading. A request with last_segment set starts the count and
//   raises busy. Segments beyond MAX_SEGMENTS are dropped.
//   Segments sit in a chain of cells that rotates one place per cycle, while
//   scanning, past a sequencer at its head; every scan is one full turn of
//   the chain. The permutation check is one scan, each merge a scan and a
//   merge step, and each block move a clear step, scans for marks, best
//   block and target, a delete and an insert, then further merge scans.
//   Results then come out as MAX_MOVE_LEN back-to-back strobes, bin one
//   first, last_bin set on the final one; busy drops in the next cycle.
//   The receiver cannot stall: each result is valid for its strobe cycle.
//   Reset clears the segment count, the tally and the histogram; the cell
//   contents need no clearing since only loaded cells are read.
`timescale 1ns / 1ps

module block_move_counter
    import bmc_pkg::*;
#(
    parameter int MAX_SEGMENTS = 256,
    parameter int MAX_MOVE_LEN = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     strobe,
    output result_t  result
);

    localparam int IW  = $clog2(MAX_SEGMENTS);
    localparam int CW  = $clog2(MAX_SEGMENTS + 1);
    localparam int HBW = $clog2(MAX_MOVE_LEN + 1);
    localparam int XW  = CW + RANK_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PERM,
        S_MSCAN,
        S_MERGE,
        S_MCLR,
        S_MP1,
        S_MP2,
        S_MP3,
        S_MDEL,
        S_MINS,
        S_EMIT
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     count_reg;
    logic [IW-1:0]     k_reg;
    logic [RANK_W-1:0] a_reg;
    logic [RANK_W-1:0] b_reg;
    logic [LEN_W-1:0]  alen_reg;
    logic              found_reg;
    logic [IW-1:0]     pos_reg;
    logic [RANK_W-1:0] base_reg;
    logic [LEN_W-1:0]  sum_reg;
    logic [RANK_W-1:0] brank_reg;
    logic [LEN_W-1:0]  blen_reg;
    logic [1:0]        bred_reg;
    logic [IW-1:0]     fpos_reg;
    logic [IW-1:0]     ipos_reg;
    logic [CNT_W-1:0]  tally_reg;
    logic [HBW-1:0]    ek_reg;

    cell_t             cq   [MAX_SEGMENTS];
    cell_t             ceff [MAX_SEGMENTS];
    cell_t             head;
    bcast_t            bc;
    logic [IW-1:0]     bc_pos;
    logic [IW-1:0]     last_pos;
    logic              pass_end;
    logic              accept;
    logic              room;
    logic              perm_bad;
    logic              merge_hit;
    logic [LEN_W:0]    wide_sum;
    logic [LEN_W-1:0]  sat_sum;
    logic [1:0]        red;
    logic              take_best;
    logic [RANK_W-1:0] find_rank;
    logic [IW-1:0]     pos_after;
    logic [IW-1:0]     ins_pos;
    logic [HBW-1:0]    move_bin;
    logic [CNT_W-1:0]  hist_head;

    assign head     = cq[0];
    assign last_pos = IW'(count_reg - CW'(1));
    assign pass_end = k_reg == last_pos;
    assign accept   = start && !busy;
    assign room     = count_reg < CW'(MAX_SEGMENTS);
    assign busy     = state_reg != S_IDLE;
    assign strobe   = state_reg == S_EMIT;

    assign perm_bad  = head.rank == '0 || XW'(head.rank) > XW'(count_reg) || head.dup;
    assign merge_hit = k_reg != '0 && !found_reg
                       && TGT_W'(head.rank) == TGT_W'(a_reg) + TGT_W'(1);
    assign wide_sum  = (LEN_W + 1)'(alen_reg) + (LEN_W + 1)'(head.len);
    assign sat_sum   = wide_sum[LEN_W] ? {LEN_W{1'b1}} : wide_sum[LEN_W-1:0];

    assign red       = 2'd1 + 2'(head.ins) + 2'(head.del);
    assign take_best = k_reg == '0 || red > bred_reg
                       || (red == bred_reg && (head.len < blen_reg
                       || (head.len == blen_reg && head.rank < brank_reg)));
    assign find_rank = (brank_reg == RANK_W'(1)) ? RANK_W'(2) : brank_reg - RANK_W'(1);
    assign pos_after = (fpos_reg > pos_reg) ? fpos_reg - IW'(1) : fpos_reg;
    assign ins_pos   = (brank_reg == RANK_W'(1)) ? pos_after : pos_after + IW'(1);

    always_comb
    begin
        if (blen_reg == '0)
        begin
            move_bin = HBW'(1);
        end
        else if (blen_reg < LEN_W'(MAX_MOVE_LEN))
        begin
            move_bin = HBW'(blen_reg);
        end
        else
        begin
            move_bin = HBW'(MAX_MOVE_LEN);
        end
    end

    always_comb
    begin
        bc         = '0;
        bc.op      = OP_HOLD;
        bc_pos     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && room)
                begin
                    bc.op   = OP_LOAD;
                    bc_pos  = IW'(count_reg);
                    bc.rank = request.segment_rank;
                    bc.len  = request.segment_length;
                end
            end
            S_PERM:
            begin
                bc.op     = OP_ROT;
                bc.dup_en = 1'b1;
                bc.rank   = head.rank;
            end
            S_MSCAN, S_MP2, S_MP3:
            begin
                bc.op = OP_ROT;
            end
            S_MP1:
            begin
                bc.op      = OP_ROT;
                bc.ins_en  = k_reg != '0 && TGT_W'(head.rank) == TGT_W'(a_reg) + TGT_W'(2);
                bc.ins_tgt = TGT_W'(a_reg) + TGT_W'(1);
                bc.del_en  = k_reg > IW'(1) && TGT_W'(head.rank) == TGT_W'(b_reg) + TGT_W'(1);
                bc.del_tgt = TGT_W'(a_reg);
            end
            S_MERGE:
            begin
                bc.op   = OP_MERGE;
                bc_pos  = pos_reg;
                bc.len  = sum_reg;
                bc.base = base_reg;
            end
            S_MCLR:
            begin
                bc.op = OP_CLR;
            end
            S_MDEL:
            begin
                bc.op  = OP_DEL;
                bc_pos = pos_reg;
            end
            S_MINS:
            begin
                bc.op   = OP_INS;
                bc_pos  = ipos_reg;
                bc.rank = brank_reg;
                bc.len  = blen_reg;
            end
            S_EMIT:
            begin
                bc.op = OP_HOLD;
            end
            default:
            begin
                bc.op = OP_HOLD;
            end
        endcase
    end

    for (genvar i = 0; i < MAX_SEGMENTS; i++)
    begin : g_cell
        localparam int RI = (i + 1) % MAX_SEGMENTS;
        localparam int LI = (i == 0) ? 0 : i - 1;

        bmc_cell #(
            .MAX_SEGMENTS (MAX_SEGMENTS),
            .IDX          (i)
        ) u_cell (
            .clk       (clk),
            .bc        (bc),
            .pos       (bc_pos),
            .last      (last_pos),
            .right_eff (ceff[RI]),
            .left_q    (cq[LI]),
            .head_eff  (ceff[0]),
            .q         (cq[i]),
            .eff       (ceff[i])
        );
    end

    bmc_hist #(
        .MAX_MOVE_LEN (MAX_MOVE_LEN)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .inc   (state_reg == S_MINS),
        .bin   (move_bin),
        .shift (state_reg == S_EMIT),
        .head  (hist_head)
    );

    always_comb
    begin
        result.bin_index   = BIN_W'(ek_reg + HBW'(1));
        result.bin_moves   = hist_head;
        result.moves_total = tally_reg;
        result.last_bin    = ek_reg == HBW'(MAX_MOVE_LEN - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            k_reg     <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            alen_reg  <= '0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
            base_reg  <= '0;
            sum_reg   <= '0;
            brank_reg <= '0;
            blen_reg  <= '0;
            bred_reg  <= '0;
            fpos_reg  <= '0;
            ipos_reg  <= '0;
            tally_reg <= '0;
            ek_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (room)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        if (request.last_segment)
                        begin
                            k_reg     <= '0;
                            state_reg <= S_PERM;
                        end
                    end
                end
                S_PERM:
                begin
                    k_reg <= k_reg + IW'(1);
                    if (perm_bad)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else if (pass_end)
                    begin
                        k_reg     <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_MSCAN;
                    end
                end
                S_MSCAN:
                begin
                    k_reg    <= k_reg + IW'(1);
                    a_reg    <= head.rank;
                    alen_reg <= head.len;
                    if (merge_hit)
                    begin
                        found_reg <= 1'b1;
                        pos_reg   <= k_reg - IW'(1);
                        base_reg  <= a_reg;
                        sum_reg   <= sat_sum;
                    end
                    if (pass_end)
                    begin
                        k_reg <= '0;
                        if (found_reg || merge_hit)
                        begin
                            state_reg <= S_MERGE;
                        end
                        else if (count_reg > CW'(1))
                        begin
                            state_reg <= S_MCLR;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_MERGE:
                begin
                    count_reg <= count_reg - CW'(1);
                    found_reg <= 1'b0;
                    k_reg     <= '0;
                    state_reg <= S_MSCAN;
                end
                S_MCLR:
                begin
                    k_reg     <= '0;
                    state_reg <= S_MP1;
                end
                S_MP1:
                begin
                    k_reg <= k_reg + IW'(1);
                    a_reg <= head.rank;
                    b_reg <= a_reg;
                    if (pass_end)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_MP2;
                    end
                end
                S_MP2:
                begin
                    k_reg <= k_reg + IW'(1);
                    if (take_best)
                    begin
                        brank_reg <= head.rank;
                        blen_reg  <= head.len;
                        bred_reg  <= red;
                        pos_reg   <= k_reg;
                    end
                    if (pass_end)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_MP3;
                    end
                end
                S_MP3:
                begin
                    k_reg <= k_reg + IW'(1);
                    if (head.rank == find_rank)
                    begin
                        fpos_reg <= k_reg;
                    end
                    if (pass_end)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_MDEL;
                    end
                end
                S_MDEL:
                begin
                    count_reg <= count_reg - CW'(1);
                    ipos_reg  <= ins_pos;
                    state_reg <= S_MINS;
                end
                S_MINS:
                begin
                    count_reg <= count_reg + CW'(1);
                    if (tally_reg != {CNT_W{1'b1}})
                    begin
                        tally_reg <= tally_reg + CNT_W'(1);
                    end
                    k_reg     <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_MSCAN;
                end
                S_EMIT:
                begin
                    ek_reg <= ek_reg + HBW'(1);
                    if (ek_reg == HBW'(MAX_MOVE_LEN - 1))
                    begin
                        ek_reg    <= '0;
                        count_reg <= '0;
                        tally_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/bmc_checker.sv */
// port level checks of the result burst, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmc_checker
    import bmc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    busy,
    input logic    strobe,
    input result_t result
);

    // results only come out while a request is being worked on
    `BMC_ASSERT(a_strobe_busy, strobe |-> busy, "result strobe while not busy")

    // the burst runs without gaps up to the last bin
    `BMC_ASSERT_NEXT(a_burst_run, strobe && !result.last_bin, strobe, "gap in result burst")

    // bins count up by one within the burst
    `BMC_ASSERT_NEXT(a_bin_step, strobe && !result.last_bin, result.bin_index == $past(result.bin_index) + 6'd1, "bin index did not step")

    // the total is the same on every result of one burst
    `BMC_ASSERT_NEXT(a_total_hold, strobe && !result.last_bin, result.moves_total == $past(result.moves_total), "total changed in burst")

    // after the last bin the block is ready again
    `BMC_ASSERT_NEXT(a_burst_end, strobe && result.last_bin, !strobe && !busy, "busy after last bin")

endmodule

bind block_move_counter bmc_checker u_bmc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);
